// ----- rtl/core/tbsi_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tbsi_pkg: shared types, codes and saturating helpers
// Signed Q24.40 arithmetic support for the two-body spring integrator.
// ----------------------------------------------------------------------------
package tbsi_pkg;

   localparam int Q_BITS     = 40;
   localparam int CSR_IDX_W  = 3;

   localparam logic [63:0] MAX_VALUE = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MIN_VALUE = 64'h8000_0000_0000_0000;

   localparam logic [62:0] RESET_TIME_STEP      = 63'd1099511627776;
   localparam logic [62:0] RESET_TIME_OVER_MASS = 63'd1099511627776;
   localparam logic [62:0] RESET_SPRING_CONST   = 63'd2466204581101568;
   localparam logic [62:0] RESET_REST_LENGTH    = 63'd1206164255670;

   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_OVER_MASS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRING_CONST   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REST_LENGTH    = 3'd3;

   localparam logic [1:0] ACT_LOAD_POS = 2'd0;
   localparam logic [1:0] ACT_LOAD_VEL = 2'd1;
   localparam logic [1:0] ACT_TICK     = 2'd2;

   localparam logic [1:0] AXIS_UNUSED  = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic               atom;
      logic [1:0]         axis;
      logic signed [63:0] load_value;
   } req_type;

   typedef struct packed {
      logic signed [63:0] pos_x;
      logic signed [63:0] pos_y;
      logic signed [63:0] pos_z;
      logic signed [63:0] vel_x;
      logic signed [63:0] vel_y;
      logic signed [63:0] vel_z;
      logic signed [63:0] force_x;
      logic signed [63:0] force_y;
      logic signed [63:0] force_z;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic sqrt_mode;
   } rd_ctl_type;

   typedef struct packed {
      logic        sat;
      logic [63:0] value;
   } sat_type;

   function automatic logic [63:0] mag_of(input logic [63:0] a);
      return a[63] ? (64'd0 - a) : a;
   endfunction

   // sign plus wide magnitude into a clipped signed 64-bit value
   function automatic sat_type sat_pack(input logic neg, input logic [127:0] mag);
      sat_type res;
      res.sat   = 1'b0;
      res.value = mag[63:0];
      if (neg) begin
         if ((mag[127:64] != 64'd0) || (mag[63:0] > MIN_VALUE)) begin
            res.sat   = 1'b1;
            res.value = MIN_VALUE;
         end else begin
            res.value = 64'd0 - mag[63:0];
         end
      end else if (mag[127:63] != 65'd0) begin
         res.sat   = 1'b1;
         res.value = MAX_VALUE;
      end
      return res;
   endfunction

   function automatic sat_type sat_add(input logic [63:0] a, input logic [63:0] b);
      sat_type res;
      res.value = a + b;
      res.sat   = 1'b0;
      if ((a[63] == b[63]) && (res.value[63] != a[63])) begin
         res.sat   = 1'b1;
         res.value = a[63] ? MIN_VALUE : MAX_VALUE;
      end
      return res;
   endfunction

   function automatic sat_type sat_sub(input logic [63:0] a, input logic [63:0] b);
      sat_type res;
      res.value = a - b;
      res.sat   = 1'b0;
      if ((a[63] != b[63]) && (res.value[63] != a[63])) begin
         res.sat   = 1'b1;
         res.value = a[63] ? MIN_VALUE : MAX_VALUE;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/tbsi_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tbsi_mul: iterative 64x64 unsigned multiplier
// One 32x32 partial product per cycle, accumulated into the 128-bit product.
// ----------------------------------------------------------------------------
module tbsi_mul (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [63:0]  op_a,
   input  wire logic [63:0]  op_b,
   output logic              done,
   output logic [127:0]      prod
);

   logic [63:0]  a_ff, a_in;
   logic [63:0]  b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [31:0]  a_half, b_half;
   logic [63:0]  partial;
   logic [127:0] partial_sh;

   always_comb begin
      a_half  = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
      b_half  = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      partial = a_half * b_half;
      unique case (cnt_ff)
         2'd0:    partial_sh = {64'd0, partial};
         2'd3:    partial_sh = {partial, 64'd0};
         default: partial_sh = {32'd0, partial, 32'd0};
      endcase
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         acc_in  = 128'd0;
         cnt_in  = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + partial_sh;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule
`default_nettype wire

// ----- rtl/core/tbsi_root_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tbsi_root_div: shared shift-subtract unit
// Integer square root of a 128-bit value (64 steps) or 128/64 division
// (128 steps), one result bit per cycle.
// ----------------------------------------------------------------------------
module tbsi_root_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tbsi_pkg::rd_ctl_type ctl,
   input  wire logic [127:0]         operand,
   input  wire logic [63:0]          divisor,
   output logic                      done,
   output logic [127:0]              result
);

   logic [127:0] work_ff, work_in;
   logic [66:0]  rem_ff, rem_in;
   logic [63:0]  root_ff, root_in;
   logic [63:0]  div_ff, div_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic         mode_ff, mode_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [66:0]  rem_sh, trial, rem_sub;
   logic         ge;
   logic         last;

   always_comb begin
      if (mode_ff) begin
         rem_sh = {rem_ff[64:0], work_ff[127:126]};
         trial  = {1'b0, root_ff, 2'b01};
      end else begin
         rem_sh = {2'd0, rem_ff[63:0], work_ff[127]};
         trial  = {3'd0, div_ff};
      end
      ge      = (rem_sh >= trial);
      rem_sub = rem_sh - trial;
      last    = mode_ff ? (cnt_ff == 7'd63) : (cnt_ff == 7'd127);
   end

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      mode_in = mode_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         work_in = operand;
         rem_in  = 67'd0;
         root_in = 64'd0;
         div_in  = divisor;
         cnt_in  = 7'd0;
         mode_in = ctl.sqrt_mode;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? rem_sub : rem_sh;
         root_in = {root_ff[62:0], ge};
         work_in = mode_ff ? {work_ff[125:0], 2'b00} : {work_ff[126:0], ge};
         cnt_in  = cnt_ff + 7'd1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
      mode_ff <= mode_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = mode_ff ? {64'd0, root_ff} : work_ff;

endmodule
`default_nettype wire

// ----- rtl/core/two_body_spring_integrator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// two_body_spring_integrator: harmonic bond, Euler stepping in Q24.40
// Holds two atoms' positions, velocities and bond forces and steps them.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : input items. Loads write one coordinate of a position or
//            velocity. A tick advances the system one step.
//   rsp_*  : one item per tick with atom 0's position, velocity, force and
//            a saturation flag. Loads produce nothing.
//   csr_*  : register writes, ready only while idle.
// Steps: a tick runs six products for the position update, three for the
//   squared distance, a 64-step square root, one product for the spring
//   force, three products each followed by a 128-step division, and six
//   products for the velocity update, all on the shared multiplier and the
//   shared shift-subtract unit. A zero distance skips the force steps.
// req_ready is low while a tick is being worked.
// Reset clears all atom state and loads the register defaults.
// A stalled receiver holds the result in the output register; the next item
//   is still taken, and a following tick waits at its end until the slot frees.
// ----------------------------------------------------------------------------
module two_body_spring_integrator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire tbsi_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output tbsi_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [tbsi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [63:0]                          csr_data
);

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_POS_MUL   = 5'd1;
   localparam logic [4:0] S_POS_ACC   = 5'd2;
   localparam logic [4:0] S_DIST_A    = 5'd3;
   localparam logic [4:0] S_DIST_B    = 5'd4;
   localparam logic [4:0] S_SQ_MUL    = 5'd5;
   localparam logic [4:0] S_SQ_ACC    = 5'd6;
   localparam logic [4:0] S_ROOT      = 5'd7;
   localparam logic [4:0] S_ROOT_WAIT = 5'd8;
   localparam logic [4:0] S_F_MUL     = 5'd9;
   localparam logic [4:0] S_F_WAIT    = 5'd10;
   localparam logic [4:0] S_C_MUL     = 5'd11;
   localparam logic [4:0] S_C_WAIT    = 5'd12;
   localparam logic [4:0] S_C_DIV     = 5'd13;
   localparam logic [4:0] S_C_DIVW    = 5'd14;
   localparam logic [4:0] S_V_MUL     = 5'd15;
   localparam logic [4:0] S_V_ACC     = 5'd16;
   localparam logic [4:0] S_DONE      = 5'd17;

   logic [4:0]   state_ff, state_in;
   logic [2:0]   idx_ff, idx_in;
   logic [62:0]  dt_ff, dt_in;
   logic [62:0]  tom_ff, tom_in;
   logic [62:0]  kspr_ff, kspr_in;
   logic [62:0]  rlen_ff, rlen_in;
   logic [63:0]  pos_ff [6];
   logic [63:0]  pos_in [6];
   logic [63:0]  vel_ff [6];
   logic [63:0]  vel_in [6];
   logic [63:0]  frc_ff [6];
   logic [63:0]  frc_in [6];
   logic [63:0]  dvec_ff [3];
   logic [63:0]  dvec_in [3];
   logic [127:0] sum_ff, sum_in;
   logic [63:0]  rdist_ff, rdist_in;
   logic [63:0]  fspr_ff, fspr_in;
   logic [63:0]  tmp_ff, tmp_in;
   logic         sat_ff, sat_in;
   logic         rsp_valid_ff, rsp_valid_in;
   tbsi_pkg::rsp_type rsp_ff, rsp_in;

   logic [2:0]   pos_addr;
   logic [2:0]   idx_hi;
   logic [1:0]   idx_lo;
   logic [63:0]  pos_rd, vel_rd, frc_rd, dvec_rd;
   logic         mul_start, mul_done;
   logic [63:0]  mul_a, mul_b;
   logic [127:0] mul_prod;
   tbsi_pkg::rd_ctl_type rd_ctl;
   logic         rd_done;
   logic [127:0] rd_result;
   logic [63:0]  over, diff;
   logic         diff_sat;
   tbsi_pkg::sat_type pk, ad, ng;
   logic [2:0]   load_addr;

   tbsi_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   tbsi_root_div u_root_div (
      .clock   (clock),
      .reset   (reset),
      .ctl     (rd_ctl),
      .operand (state_ff == S_ROOT ? sum_ff : mul_prod),
      .divisor (rdist_ff),
      .done    (rd_done),
      .result  (rd_result)
   );

   assign idx_hi    = idx_ff + 3'd3;
   assign idx_lo    = idx_ff[1:0];
   assign pos_addr  = (state_ff == S_DIST_B) ? idx_hi : idx_ff;
   assign pos_rd    = pos_ff[pos_addr];
   assign vel_rd    = vel_ff[idx_ff];
   assign frc_rd    = frc_ff[idx_ff];
   assign dvec_rd   = dvec_ff[idx_lo];
   assign load_addr = req_data.atom ? ({1'b0, req_data.axis} + 3'd3) : {1'b0, req_data.axis};

   // distance term: rest_length - r with the negative side clipped
   always_comb begin
      over     = rdist_ff - {1'b0, rlen_ff};
      diff_sat = 1'b0;
      if (rdist_ff > {1'b0, rlen_ff}) begin
         if (over > tbsi_pkg::MIN_VALUE) begin
            diff     = tbsi_pkg::MIN_VALUE;
            diff_sat = 1'b1;
         end else begin
            diff = 64'd0 - over;
         end
      end else begin
         diff = {1'b0, rlen_ff} - rdist_ff;
      end
   end

   // multiplier operands and root/divide start control
   always_comb begin
      mul_start = 1'b0;
      mul_a     = tbsi_pkg::mag_of(dvec_rd);
      mul_b     = tbsi_pkg::mag_of(dvec_rd);
      rd_ctl    = '0;
      unique case (state_ff)
         S_POS_MUL: begin
            mul_start = 1'b1;
            mul_a     = tbsi_pkg::mag_of(vel_rd);
            mul_b     = {1'b0, dt_ff};
         end
         S_SQ_MUL: begin
            mul_start = 1'b1;
         end
         S_F_MUL: begin
            mul_start = 1'b1;
            mul_a     = tbsi_pkg::mag_of(diff);
            mul_b     = {1'b0, kspr_ff};
         end
         S_C_MUL: begin
            mul_start = 1'b1;
            mul_b     = tbsi_pkg::mag_of(fspr_ff);
         end
         S_V_MUL: begin
            mul_start = 1'b1;
            mul_a     = tbsi_pkg::mag_of(frc_rd);
            mul_b     = {1'b0, tom_ff};
         end
         S_ROOT: begin
            rd_ctl.start     = 1'b1;
            rd_ctl.sqrt_mode = 1'b1;
         end
         S_C_DIV: begin
            rd_ctl.start = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      dt_in        = dt_ff;
      tom_in       = tom_ff;
      kspr_in      = kspr_ff;
      rlen_in      = rlen_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      frc_in       = frc_ff;
      dvec_in      = dvec_ff;
      sum_in       = sum_ff;
      rdist_in     = rdist_ff;
      fspr_in      = fspr_ff;
      tmp_in       = tmp_ff;
      sat_in       = sat_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      pk           = '0;
      ad           = '0;
      ng           = '0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tbsi_pkg::CSR_TIME_STEP:      dt_in   = csr_data[62:0];
            tbsi_pkg::CSR_TIME_OVER_MASS: tom_in  = csr_data[62:0];
            tbsi_pkg::CSR_SPRING_CONST:   kspr_in = csr_data[62:0];
            tbsi_pkg::CSR_REST_LENGTH:    rlen_in = csr_data[62:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.action == tbsi_pkg::ACT_TICK) begin
                  sat_in   = 1'b0;
                  idx_in   = 3'd0;
                  state_in = S_POS_MUL;
               end else if ((req_data.action == tbsi_pkg::ACT_LOAD_POS) &&
                            (req_data.axis != tbsi_pkg::AXIS_UNUSED)) begin
                  pos_in[load_addr] = req_data.load_value;
               end else if ((req_data.action == tbsi_pkg::ACT_LOAD_VEL) &&
                            (req_data.axis != tbsi_pkg::AXIS_UNUSED)) begin
                  vel_in[load_addr] = req_data.load_value;
               end
            end
         end
         S_POS_MUL: state_in = S_POS_ACC;
         S_POS_ACC: begin
            if (mul_done) begin
               pk = tbsi_pkg::sat_pack(vel_rd[63], {40'd0, mul_prod[127:40]});
               ad = tbsi_pkg::sat_add(pos_rd, pk.value);
               pos_in[idx_ff] = ad.value;
               sat_in = sat_ff | pk.sat | ad.sat;
               if (idx_ff == 3'd5) begin
                  idx_in   = 3'd0;
                  sum_in   = 128'd0;
                  state_in = S_DIST_A;
               end else begin
                  idx_in   = idx_ff + 3'd1;
                  state_in = S_POS_MUL;
               end
            end
         end
         S_DIST_A: begin
            tmp_in   = pos_rd;
            state_in = S_DIST_B;
         end
         S_DIST_B: begin
            ad = tbsi_pkg::sat_sub(tmp_ff, pos_rd);
            dvec_in[idx_lo] = ad.value;
            sat_in   = sat_ff | ad.sat;
            state_in = S_SQ_MUL;
         end
         S_SQ_MUL: state_in = S_SQ_ACC;
         S_SQ_ACC: begin
            if (mul_done) begin
               sum_in = sum_ff + mul_prod;
               if (idx_ff == 3'd2) begin
                  idx_in   = 3'd0;
                  state_in = S_ROOT;
               end else begin
                  idx_in   = idx_ff + 3'd1;
                  state_in = S_DIST_A;
               end
            end
         end
         S_ROOT: state_in = S_ROOT_WAIT;
         S_ROOT_WAIT: begin
            if (rd_done) begin
               rdist_in = rd_result[63:0];
               idx_in   = 3'd0;
               if (rd_result[63:0] == 64'd0) begin
                  // zero distance: no bond direction, drop all forces
                  sat_in = 1'b1;
                  for (int i = 0; i < 6; i++) frc_in[i] = 64'd0;
                  state_in = S_V_MUL;
               end else begin
                  state_in = S_F_MUL;
               end
            end
         end
         S_F_MUL: begin
            tmp_in   = diff;
            sat_in   = sat_ff | diff_sat;
            state_in = S_F_WAIT;
         end
         S_F_WAIT: begin
            if (mul_done) begin
               pk = tbsi_pkg::sat_pack(tmp_ff[63], {40'd0, mul_prod[127:40]});
               fspr_in  = pk.value;
               sat_in   = sat_ff | pk.sat;
               state_in = S_C_MUL;
            end
         end
         S_C_MUL: state_in = S_C_WAIT;
         S_C_WAIT: begin
            if (mul_done) state_in = S_C_DIV;
         end
         S_C_DIV: state_in = S_C_DIVW;
         S_C_DIVW: begin
            if (rd_done) begin
               pk = tbsi_pkg::sat_pack(dvec_rd[63] ^ fspr_ff[63], rd_result);
               ng = tbsi_pkg::sat_sub(64'd0, pk.value);
               frc_in[idx_ff] = pk.value;
               frc_in[idx_hi] = ng.value;
               sat_in = sat_ff | pk.sat | ng.sat;
               if (idx_ff == 3'd2) begin
                  idx_in   = 3'd0;
                  state_in = S_V_MUL;
               end else begin
                  idx_in   = idx_ff + 3'd1;
                  state_in = S_C_MUL;
               end
            end
         end
         S_V_MUL: state_in = S_V_ACC;
         S_V_ACC: begin
            if (mul_done) begin
               pk = tbsi_pkg::sat_pack(frc_rd[63], {40'd0, mul_prod[127:40]});
               ad = tbsi_pkg::sat_add(vel_rd, pk.value);
               vel_in[idx_ff] = ad.value;
               sat_in = sat_ff | pk.sat | ad.sat;
               if (idx_ff == 3'd5) begin
                  idx_in   = 3'd0;
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_ff + 3'd1;
                  state_in = S_V_MUL;
               end
            end
         end
         S_DONE: begin
            // hold until the output slot is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.pos_x     = pos_ff[0];
               rsp_in.pos_y     = pos_ff[1];
               rsp_in.pos_z     = pos_ff[2];
               rsp_in.vel_x     = vel_ff[0];
               rsp_in.vel_y     = vel_ff[1];
               rsp_in.vel_z     = vel_ff[2];
               rsp_in.force_x   = frc_ff[0];
               rsp_in.force_y   = frc_ff[1];
               rsp_in.force_z   = frc_ff[2];
               rsp_in.saturated = sat_ff;
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      dvec_ff  <= dvec_in;
      sum_ff   <= sum_in;
      rdist_ff <= rdist_in;
      fspr_ff  <= fspr_in;
      tmp_ff   <= tmp_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= 3'd0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dt_ff        <= tbsi_pkg::RESET_TIME_STEP;
         tom_ff       <= tbsi_pkg::RESET_TIME_OVER_MASS;
         kspr_ff      <= tbsi_pkg::RESET_SPRING_CONST;
         rlen_ff      <= tbsi_pkg::RESET_REST_LENGTH;
         for (int i = 0; i < 6; i++) begin
            pos_ff[i] <= 64'd0;
            vel_ff[i] <= 64'd0;
            frc_ff[i] <= 64'd0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
         dt_ff        <= dt_in;
         tom_ff       <= tom_in;
         kspr_ff      <= kspr_in;
         rlen_ff      <= rlen_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         frc_ff       <= frc_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = (state_ff == S_IDLE);

`ifndef ASSERT_OFF
   property p_tick_leaves_idle;
      @(posedge clock) disable iff (reset)
         (req_valid && req_ready && (req_data.action == tbsi_pkg::ACT_TICK))
            |=> (state_ff != S_IDLE);
   endproperty
   a_tick_leaves_idle: assert property (p_tick_leaves_idle)
      else $error("tick item did not start a step");

   property p_rsp_from_done;
      @(posedge clock) disable iff (reset)
         $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE);
   endproperty
   a_rsp_from_done: assert property (p_rsp_from_done)
      else $error("result raised outside the final state");

   property p_mul_done_pulse;
      @(posedge clock) disable iff (reset)
         mul_done |=> !mul_done;
   endproperty
   a_mul_done_pulse: assert property (p_mul_done_pulse)
      else $error("multiplier done held longer than one cycle");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_two_body_spring_integrator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_body_spring_integrator: self-checking bench for the spring integrator
// Drives load and tick items with bursty gaps, stalls the result side, and
// checks every step result against an in-bench fixed-point model of the bond.
// ----------------------------------------------------------------------------
module tb_two_body_spring_integrator;

   localparam int    CYCLE_LIMIT = 3000000;
   localparam int    TICK_CYCLES = 700;
   localparam [63:0] ONE_Q      = 64'd1 << 40;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   tbsi_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   tbsi_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [tbsi_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   two_body_spring_integrator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // bond model state
   logic [63:0] m_dt, m_dtm, m_k, m_r0;
   logic [63:0] m_pos [6];
   logic [63:0] m_vel [6];
   logic [63:0] m_frc [6];
   tbsi_pkg::rsp_type step_queue [$];
   int          fail_count = 0;
   int          cycle_count = 0;
   int          stall_mode = 0;

   function automatic logic [63:0] mag(input logic [63:0] a);
      return a[63] ? (64'd0 - a) : a;
   endfunction

   function automatic logic [63:0] clip(input logic neg, input logic [127:0] m,
                                        inout logic sat);
      if (neg) begin
         if (m > {64'd0, 64'h8000_0000_0000_0000}) begin
            sat = 1'b1;
            return 64'h8000_0000_0000_0000;
         end
         return 64'd0 - m[63:0];
      end
      if (m > {64'd0, 64'h7FFF_FFFF_FFFF_FFFF}) begin
         sat = 1'b1;
         return 64'h7FFF_FFFF_FFFF_FFFF;
      end
      return m[63:0];
   endfunction

   function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b,
                                        inout logic sat);
      logic [127:0] p;
      p = ({64'd0, mag(a)} * {64'd0, b}) >> 40;
      return clip(a[63], p, sat);
   endfunction

   function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b,
                                           inout logic sat);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         sat = 1'b1;
         return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
      return s;
   endfunction

   function automatic logic [63:0] sub_sat(input logic [63:0] a, input logic [63:0] b,
                                           inout logic sat);
      logic [63:0] s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63]) begin
         sat = 1'b1;
         return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
      return s;
   endfunction

   function automatic logic [63:0] root_of(input logic [127:0] n);
      logic [63:0] res, c;
      res = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         c = res | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= n) res = c;
      end
      return res;
   endfunction

   task automatic bond_reset();
      m_dt = {1'b0, tbsi_pkg::RESET_TIME_STEP};
      m_dtm = {1'b0, tbsi_pkg::RESET_TIME_OVER_MASS};
      m_k = {1'b0, tbsi_pkg::RESET_SPRING_CONST};
      m_r0 = {1'b0, tbsi_pkg::RESET_REST_LENGTH};
      for (int i = 0; i < 6; i++) begin
         m_pos[i] = '0;
         m_vel[i] = '0;
         m_frc[i] = '0;
      end
   endtask

   // advance the model by one item; queue a step result for ticks
   task automatic bond_apply(input tbsi_pkg::req_type it);
      logic sat;
      logic [63:0] d [3];
      logic [127:0] sum, q;
      logic [63:0] r, diff, f, c, m, t;
      tbsi_pkg::rsp_type e;
      sat = 1'b0;
      sum = '0;
      if (it.action == tbsi_pkg::ACT_LOAD_POS || it.action == tbsi_pkg::ACT_LOAD_VEL) begin
         if (it.axis != tbsi_pkg::AXIS_UNUSED) begin
            if (it.action == tbsi_pkg::ACT_LOAD_POS) m_pos[it.atom*3 + it.axis] = it.load_value;
            else m_vel[it.atom*3 + it.axis] = it.load_value;
         end
         return;
      end
      if (it.action != tbsi_pkg::ACT_TICK) return;
      for (int i = 0; i < 6; i++) begin
         t = qmul(m_vel[i], m_dt, sat);
         m_pos[i] = add_sat(m_pos[i], t, sat);
      end
      for (int i = 0; i < 3; i++) begin
         d[i] = sub_sat(m_pos[i], m_pos[3+i], sat);
         sum = sum + {64'd0, mag(d[i])} * {64'd0, mag(d[i])};
      end
      r = root_of(sum);
      if (r == 0) begin
         sat = 1'b1;
         for (int i = 0; i < 6; i++) m_frc[i] = '0;
      end else begin
         if (r > m_r0) begin
            m = r - m_r0;
            if (m > 64'h8000_0000_0000_0000) begin
               m = 64'h8000_0000_0000_0000;
               sat = 1'b1;
            end
            diff = 64'd0 - m;
         end else begin
            diff = m_r0 - r;
         end
         f = qmul(diff, m_k, sat);
         for (int i = 0; i < 3; i++) begin
            q = ({64'd0, mag(d[i])} * {64'd0, mag(f)}) / {64'd0, r};
            c = clip(d[i][63] ^ f[63], q, sat);
            m_frc[i] = c;
            m_frc[3+i] = sub_sat(64'd0, c, sat);
         end
      end
      for (int i = 0; i < 6; i++) begin
         t = qmul(m_frc[i], m_dtm, sat);
         m_vel[i] = add_sat(m_vel[i], t, sat);
      end
      e.pos_x = m_pos[0]; e.pos_y = m_pos[1]; e.pos_z = m_pos[2];
      e.vel_x = m_vel[0]; e.vel_y = m_vel[1]; e.vel_z = m_vel[2];
      e.force_x = m_frc[0]; e.force_y = m_frc[1]; e.force_z = m_frc[2];
      e.saturated = sat;
      step_queue.push_back(e);
   endtask

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout", $time);
         $display("** two_body_spring_integrator: FAILED **");
         $finish;
      end
   end

   // result stall pattern
   always @(negedge clock) begin
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   task automatic cmp(input string nm, input logic [63:0] ex, input logic [63:0] ac);
      if (ex !== ac) begin
         $display("%0t %s mismatch: expected %h actual %h", $time, nm, ex, ac);
         fail_count++;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      tbsi_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (step_queue.size() == 0) begin
            $display("%0t unexpected step result: expected none actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            e = step_queue.pop_front();
            cmp("pos_x", e.pos_x, rsp_data.pos_x);
            cmp("pos_y", e.pos_y, rsp_data.pos_y);
            cmp("pos_z", e.pos_z, rsp_data.pos_z);
            cmp("vel_x", e.vel_x, rsp_data.vel_x);
            cmp("vel_y", e.vel_y, rsp_data.vel_y);
            cmp("vel_z", e.vel_z, rsp_data.vel_z);
            cmp("force_x", e.force_x, rsp_data.force_x);
            cmp("force_y", e.force_y, rsp_data.force_y);
            cmp("force_z", e.force_z, rsp_data.force_z);
            cmp("saturated", {63'd0, e.saturated}, {63'd0, rsp_data.saturated});
         end
      end
   end

   int burst_left = 0;

   // called at a falling edge; valid stays high into the next item of a burst
   task automatic send_item(input tbsi_pkg::req_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bond_apply(it);
      @(negedge clock);
   endtask

   task automatic load(input logic [1:0] act, input logic at, input logic [1:0] ax,
                       input logic [63:0] v);
      tbsi_pkg::req_type it;
      it.action = act; it.atom = at; it.axis = ax; it.load_value = v;
      send_item(it);
   endtask

   task automatic tick();
      load(tbsi_pkg::ACT_TICK, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
           {$urandom, $urandom});
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (step_queue.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (TICK_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [tbsi_pkg::CSR_IDX_W-1:0] idx, input logic [63:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == tbsi_pkg::CSR_TIME_STEP) m_dt = v & 64'h7FFF_FFFF_FFFF_FFFF;
      else if (idx == tbsi_pkg::CSR_TIME_OVER_MASS) m_dtm = v & 64'h7FFF_FFFF_FFFF_FFFF;
      else if (idx == tbsi_pkg::CSR_SPRING_CONST) m_k = v & 64'h7FFF_FFFF_FFFF_FFFF;
      else if (idx == tbsi_pkg::CSR_REST_LENGTH) m_r0 = v & 64'h7FFF_FFFF_FFFF_FFFF;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_regs(input logic [63:0] dt, input logic [63:0] dtm,
                           input logic [63:0] k, input logic [63:0] r0);
      drain();
      csr_write(tbsi_pkg::CSR_TIME_STEP, dt);
      csr_write(tbsi_pkg::CSR_TIME_OVER_MASS, dtm);
      csr_write(tbsi_pkg::CSR_SPRING_CONST, k);
      csr_write(tbsi_pkg::CSR_REST_LENGTH, r0);
   endtask

   function automatic logic [63:0] small_val();
      logic [63:0] v;
      v = {{32{1'b0}}, $urandom} << $urandom_range(0, 14);
      return $urandom_range(0, 1) ? (64'd0 - v) : v;
   endfunction

   task automatic test_default_bond();
      load(tbsi_pkg::ACT_LOAD_POS, 1'b0, 2'd0, ONE_Q);
      load(tbsi_pkg::ACT_LOAD_POS, 1'b1, 2'd0, 64'd0);
      tick();
      tick();
      // zero distance
      load(tbsi_pkg::ACT_LOAD_POS, 1'b0, 2'd0, 64'd0);
      load(tbsi_pkg::ACT_LOAD_VEL, 1'b0, 2'd0, 64'd0);
      load(tbsi_pkg::ACT_LOAD_VEL, 1'b1, 2'd0, 64'd0);
      for (int i = 0; i < 3; i++) begin
         load(tbsi_pkg::ACT_LOAD_POS, 1'b0, 2'(i), 64'd0);
         load(tbsi_pkg::ACT_LOAD_POS, 1'b1, 2'(i), 64'd0);
      end
      tick();
   endtask

   task automatic test_extremes();
      load(tbsi_pkg::ACT_LOAD_POS, 1'b0, 2'd0, 64'h7FFF_FFFF_FFFF_FFFF);
      load(tbsi_pkg::ACT_LOAD_POS, 1'b1, 2'd0, 64'h8000_0000_0000_0000);
      load(tbsi_pkg::ACT_LOAD_VEL, 1'b0, 2'd1, 64'h7FFF_FFFF_FFFF_FFFF);
      load(tbsi_pkg::ACT_LOAD_VEL, 1'b1, 2'd2, 64'h8000_0000_0000_0000);
      tick();
      // unused axis and unused action do nothing
      load(tbsi_pkg::ACT_LOAD_POS, 1'b0, tbsi_pkg::AXIS_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
      load(tbsi_pkg::ACT_LOAD_VEL, 1'b1, tbsi_pkg::AXIS_UNUSED, 64'h5555_5555_5555_5555);
      load(ACT_UNUSED, 1'b1, 2'd2, 64'hAAAA_AAAA_AAAA_AAAA);
      tick();
   endtask

   task automatic random_phase(input int n_items, input int mode);
      int kind;
      stall_mode = mode;
      for (int n = 0; n < n_items; n++) begin
         kind = $urandom_range(0, 99);
         if (kind < 30) tick();
         else if (kind < 85)
            load(2'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 2'($urandom_range(0, 2)), small_val());
         else if (kind < 93)
            load(2'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 2'($urandom_range(0, 2)), {$urandom, $urandom});
         else
            load(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                 2'($urandom_range(0, 3)), {$urandom, $urandom});
      end
   endtask

   task automatic test_config_sweep();
      set_regs(64'd0, 64'd0, 64'd0, 64'd0);
      random_phase(40, 1);
      set_regs(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      random_phase(40, 2);
      // out of range index is ignored
      drain();
      csr_write(3'd5, 64'h1234);
      csr_write(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
      random_phase(20, 0);
   endtask

   task automatic test_random();
      for (int p = 0; p < 4; p++) begin
         set_regs((64'($urandom_range(0, 4)) << 30) | (ONE_Q >> $urandom_range(0, 10)),
                  ONE_Q >> $urandom_range(0, 12),
                  (64'($urandom_range(0, 3000)) << 40) >> $urandom_range(0, 8),
                  (64'($urandom_range(0, 4)) << 40) | ({$urandom, $urandom} >> 26));
         random_phase(270, p % 3);
      end
   endtask

   initial begin
      bond_reset();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_bond();
      test_extremes();
      test_config_sweep();
      test_random();
      stall_mode = 1;
      drain();
      if (fail_count == 0 && step_queue.size() == 0)
         $display("** two_body_spring_integrator: PASSED **");
      else
         $display("** two_body_spring_integrator: FAILED **");
      $finish;
   end

endmodule
